FILE: rtl/core/poisson_stencil_row_builder_defines.svh
// Assertion macros shared by the row builder RTL.
`ifndef POISSON_STENCIL_ROW_BUILDER_DEFINES_SVH
`define POISSON_STENCIL_ROW_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define PSRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define PSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/psrb_pkg.sv
// Types and constants of the Poisson stencil row builder.
package psrb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CFG_SZ_W   = 9;
    localparam int IDX_W      = 16;
    localparam int DIV_W      = 32;
    localparam int WGT_W      = 32;

    localparam logic [1:0] CLS_FLUID = 2'd0;
    localparam logic [1:0] CLS_AIR   = 2'd1;

    typedef enum logic [2:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_INV_H_SQR_X = 3'd2,
        CFG_INV_H_SQR_Y = 3'd3,
        CFG_COMPRESSED  = 3'd4
    } cfg_idx_t;

    // One line-buffer column: newest row and the row below it.
    typedef struct packed {
        logic [1:0]       r2_cls;
        logic [IDX_W-1:0] r2_idx;
        logic [1:0]       r1_cls;
        logic [IDX_W-1:0] r1_idx;
        logic [DIV_W-1:0] r1_div;
    } entry_t;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [IDX_W-1:0]   down_column;
        logic [IDX_W-1:0]   up_column;
        logic [IDX_W-1:0]   left_column;
        logic [IDX_W-1:0]   right_column;
        logic [3:0]         neighbour_mask;
        logic [DIV_W-1:0]   rhs;
        logic [WGT_W:0]     up_weight;
        logic [WGT_W:0]     right_weight;
        logic [WGT_W+1:0]   center_weight;
        logic [IDX_W-1:0]   row_number;
    } result_t;

endpackage

FILE: rtl/core/psrb_ram.sv
// Generic simple dual-port RAM with registered read.
module psrb_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/poisson_stencil_row_builder.sv
// Top level of the Poisson stencil row builder.
//
//  channel  | direction | handshake             | payload
//  s_       | in        | s_tvalid / s_tready   | s_tdata (cell), s_tuser (kind)
//  m_       | out       | m_tvalid / m_tready   | m_tdata (row), m_tuser, m_tlast
//  cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; the result is registered.
// The rate is set by the two line-buffer RAM read ports, prefetched one column ahead.
// Reset clears positions, count, config and flags; line buffers need no clearing.
// A stalled output holds; the input is taken whenever the output register is free or drains.
`include "poisson_stencil_row_builder_defines.svh"

module poisson_stencil_row_builder #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // cell_class[1:0], divergence[33:2], zero pad
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata,   // row_number, center_weight, right_weight, up_weight,
                                    // rhs, neighbour_mask, right/left/up/down_column
    output logic         m_tuser,   // is_fluid
    output logic         m_tlast,   // grid_done
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WB  = CW + 1;
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int GWX = (WB > psrb_pkg::CFG_SZ_W) ? WB : psrb_pkg::CFG_SZ_W;
    localparam int GHX = (RW > psrb_pkg::CFG_SZ_W) ? RW : psrb_pkg::CFG_SZ_W;
    localparam int XW  = psrb_pkg::WGT_W;

    // configuration
    logic [8:0]    grid_width_reg, grid_height_reg;
    logic [XW-1:0] inv_x_reg, inv_y_reg;
    logic          compressed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            inv_x_reg       <= 32'd65536;
            inv_y_reg       <= 32'd65536;
            compressed_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (psrb_pkg::cfg_idx_t'(cfg_index))
                psrb_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                psrb_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[8:0];
                psrb_pkg::CFG_INV_H_SQR_X: inv_x_reg       <= cfg_data;
                psrb_pkg::CFG_INV_H_SQR_Y: inv_y_reg       <= cfg_data;
                psrb_pkg::CFG_COMPRESSED:  compressed_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [GWX-1:0] gw_x, w_eff_x;
    logic [GHX-1:0] gh_x, h_eff_x;
    logic [WB-1:0]  w_eff;
    logic [RW-1:0]  h_eff;

    always_comb begin
        gw_x = GWX'(grid_width_reg);
        gh_x = GHX'(grid_height_reg);
        if (gw_x == '0) begin
            w_eff_x = GWX'(1);
        end else if (gw_x > GWX'(MAX_WIDTH)) begin
            w_eff_x = GWX'(MAX_WIDTH);
        end else begin
            w_eff_x = gw_x;
        end
        if (gh_x == '0) begin
            h_eff_x = GHX'(1);
        end else if (gh_x > GHX'(MAX_HEIGHT)) begin
            h_eff_x = GHX'(MAX_HEIGHT);
        end else begin
            h_eff_x = gh_x;
        end
        w_eff = w_eff_x[WB-1:0];
        h_eff = h_eff_x[RW-1:0];
    end

    // position and count state
    logic [CW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [psrb_pkg::IDX_W-1:0]   fluid_reg, fluid_next;
    logic                         hit0_reg, hit1_reg;
    psrb_pkg::entry_t             wdata_reg;
    psrb_pkg::entry_t             left_reg;
    logic                         m_valid_reg;
    psrb_pkg::result_t            res_reg, res_next;
    logic                         fluid_out_reg, done_out_reg;

    logic                         acc, cell_act, drain_act, complete, emit, produce;
    logic [1:0]                   cls_in;
    logic [psrb_pkg::DIV_W-1:0]   div_in;
    logic [WB-1:0]                col_inc;
    logic                         row_end;
    logic [CW-1:0]                rd0_addr, rd1_addr;
    psrb_pkg::entry_t             rd0_data, rd1_data, here_e, right_e, wdata;
    logic                         has_right, has_left, has_up, has_down;
    logic                         r_ok, l_ok, u_ok, d_ok, r_fl, l_fl, u_fl, d_fl, h_fl;
    logic [XW:0]                  sel_x, sel_y;
    logic [XW+1:0]                center;
    logic [psrb_pkg::IDX_W-1:0]   up_idx;

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign cls_in   = s_tdata[1:0];
    assign div_in   = s_tdata[33:2];
    assign complete = row_reg >= h_eff;
    assign cell_act  = acc && !s_tuser && !complete;
    assign drain_act = acc && s_tuser && complete;
    assign col_inc  = {1'b0, col_reg} + WB'(1);
    assign row_end  = col_inc >= w_eff;
    assign emit     = (cell_act && (row_reg != '0)) || drain_act;

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        fluid_next = fluid_reg;
        if (cell_act) begin
            if (cls_in == psrb_pkg::CLS_FLUID) begin
                fluid_next = fluid_reg + 1'b1;
            end
            if (row_end) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end else if (drain_act) begin
            if (row_end) begin
                col_next   = '0;
                row_next   = '0;
                fluid_next = '0;
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    assign rd0_addr = col_next;
    assign rd1_addr = col_next + 1'b1;

    always_comb begin
        wdata.r2_cls = here_e.r1_cls;
        wdata.r2_idx = here_e.r1_idx;
        wdata.r1_cls = cls_in;
        wdata.r1_idx = (cls_in == psrb_pkg::CLS_FLUID) ? fluid_reg : '0;
        wdata.r1_div = div_in;
    end

    psrb_ram #(.WIDTH($bits(psrb_pkg::entry_t)), .DEPTH(MAX_WIDTH)) u_ram_here (
        .aclk  (aclk),
        .we    (cell_act),
        .waddr (col_reg),
        .wdata (wdata),
        .raddr (rd0_addr),
        .rdata (rd0_data)
    );

    psrb_ram #(.WIDTH($bits(psrb_pkg::entry_t)), .DEPTH(MAX_WIDTH)) u_ram_right (
        .aclk  (aclk),
        .we    (cell_act),
        .waddr (col_reg),
        .wdata (wdata),
        .raddr (rd1_addr),
        .rdata (rd1_data)
    );

    assign here_e  = hit0_reg ? wdata_reg : rd0_data;
    assign right_e = hit1_reg ? wdata_reg : rd1_data;

    // stencil
    always_comb begin
        has_right = !row_end;
        has_left  = col_reg != '0;
        has_up    = cell_act;
        has_down  = row_reg > RW'(1);
        up_idx    = fluid_reg;
        h_fl = here_e.r1_cls == psrb_pkg::CLS_FLUID;
        r_ok = has_right && (right_e.r1_cls <= psrb_pkg::CLS_AIR);
        l_ok = has_left  && (left_reg.r1_cls <= psrb_pkg::CLS_AIR);
        u_ok = has_up    && (cls_in <= psrb_pkg::CLS_AIR);
        d_ok = has_down  && (here_e.r2_cls <= psrb_pkg::CLS_AIR);
        r_fl = has_right && (right_e.r1_cls == psrb_pkg::CLS_FLUID);
        l_fl = has_left  && (left_reg.r1_cls == psrb_pkg::CLS_FLUID);
        u_fl = has_up    && (cls_in == psrb_pkg::CLS_FLUID);
        d_fl = has_down  && (here_e.r2_cls == psrb_pkg::CLS_FLUID);
        case ({r_ok, l_ok})
            2'b11:   sel_x = {inv_x_reg, 1'b0};
            2'b01,
            2'b10:   sel_x = {1'b0, inv_x_reg};
            default: sel_x = '0;
        endcase
        case ({u_ok, d_ok})
            2'b11:   sel_y = {inv_y_reg, 1'b0};
            2'b01,
            2'b10:   sel_y = {1'b0, inv_y_reg};
            default: sel_y = '0;
        endcase
        center = {1'b0, sel_x} + {1'b0, sel_y};

        res_next = '0;
        if (h_fl) begin
            res_next.row_number     = here_e.r1_idx;
            res_next.center_weight  = center;
            res_next.rhs            = here_e.r1_div;
            res_next.right_weight   = r_fl ? (XW+1)'(0) - {1'b0, inv_x_reg} : '0;
            res_next.up_weight      = u_fl ? (XW+1)'(0) - {1'b0, inv_y_reg} : '0;
            res_next.neighbour_mask = {d_fl, u_fl, l_fl, r_fl};
            res_next.right_column   = r_fl ? right_e.r1_idx : '0;
            res_next.left_column    = l_fl ? left_reg.r1_idx : '0;
            res_next.up_column      = u_fl ? up_idx : '0;
            res_next.down_column    = d_fl ? here_e.r2_idx : '0;
        end else begin
            res_next.center_weight  = (XW+2)'(1) << psrb_pkg::FRAC_BITS;
        end
        produce = emit && (h_fl || !compressed_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            fluid_reg   <= '0;
            hit0_reg    <= 1'b0;
            hit1_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            fluid_reg <= fluid_next;
            hit0_reg  <= cell_act && (rd0_addr == col_reg);
            hit1_reg  <= cell_act && (rd1_addr == col_reg);
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wdata_reg <= wdata;
        if (cell_act || drain_act) begin
            left_reg <= here_e;
        end
        if (produce) begin
            res_reg       <= res_next;
            fluid_out_reg <= h_fl;
            done_out_reg  <= drain_act && row_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = fluid_out_reg;
    assign m_tlast  = done_out_reg;

    `PSRB_ASSERT_NEXT(a_pos_hold, !acc, $stable(col_reg) && $stable(row_reg),
        "position moved without an input transaction")
    `PSRB_ASSERT_NEXT(a_count_hold, !acc, $stable(fluid_reg),
        "fluid count moved without an input transaction")
    `PSRB_ASSERT_NOW(a_nonfluid_clear, m_tvalid && !m_tuser,
        m_tdata[15:0] == 16'd0 && m_tdata[151:148] == 4'd0,
        "non-fluid row carries an index or neighbours")
    `PSRB_ASSERT_NOW(a_bypass_cause, hit0_reg || hit1_reg, $past(acc),
        "write bypass set without a transaction")

endmodule
